// ----- hdl/twdp_pkg.sv -----
`timescale 1ns / 1ps

package twdp_pkg;

    localparam logic [31:0] RECIP_127 = 32'h3C01_0204;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;
    localparam logic [1:0]  CODE_PLUS  = 2'd1;
    localparam logic [1:0]  CODE_MINUS = 2'd2;
    localparam logic        REG_ACT_HALF = 1'b0;

    typedef enum logic [1:0] {
        STEP_LANE = 2'd0,
        STEP_MAG  = 2'd1,
        STEP_PROD = 2'd2,
        STEP_ACC  = 2'd3
    } step_t;

    typedef enum logic {
        FPU_MUL = 1'b0,
        FPU_ADD = 1'b1
    } fpu_op_t;

    typedef struct packed {
        logic  load;
        step_t step;
        logic  start;
        logic  commit;
        logic  emit;
    } dp_cmd_t;

    typedef struct packed {
        logic direct;
        logic last;
        logic out_full;
    } dp_stat_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        special_val;
        logic               sgn;
        logic signed [11:0] ex;
        logic [50:0]        mant;
    } fpu_raw_t;

    // Rounds sgn * m * 2^e_in to single precision, nearest even. m must be nonzero.
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e_in,
                                             input logic [50:0] m);
        int          p;
        int          sh;
        int          ex;
        logic [63:0] mw;
        logic [63:0] low_mask;
        logic [24:0] mant;
        logic        guard;
        logic        sticky;
        logic [31:0] res;
        p = 0;
        for (int i = 0; i < 51; i++)
        begin
            if (m[i])
            begin
                p = i;
            end
        end
        sh = p - 23;
        if (sh < -149 - int'(e_in))
        begin
            sh = -149 - int'(e_in);
        end
        mw = 64'(m);
        guard = 1'b0;
        sticky = 1'b0;
        low_mask = '0;
        if (sh <= 0)
        begin
            mant = 25'(mw << (-sh));
        end
        else if (sh > 52)
        begin
            mant = '0;
            sticky = 1'b1;
        end
        else
        begin
            mant = 25'(mw >> sh);
            guard = mw[sh - 1];
            low_mask = (64'd1 << (sh - 1)) - 64'd1;
            sticky = |(mw & low_mask);
        end
        if (guard && (sticky || mant[0]))
        begin
            mant = mant + 25'd1;
        end
        ex = int'(e_in) + sh + 150;
        if (mant[24])
        begin
            mant = mant >> 1;
            ex = ex + 1;
        end
        if (!mant[23])
        begin
            res = {sgn, 8'd0, mant[22:0]};
        end
        else if (ex >= 255)
        begin
            res = {sgn, 8'hFF, 23'd0};
        end
        else
        begin
            res = {sgn, 8'(ex), mant[22:0]};
        end
        return res;
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        int          q;
        logic [9:0]  man;
        logic [31:0] res;
        q = 0;
        for (int i = 0; i < 10; i++)
        begin
            if (h[i])
            begin
                q = i;
            end
        end
        man = 10'(h[9:0] << (10 - q));
        if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
            begin
                res = {h[15], 31'd0};
            end
            else
            begin
                res = {h[15], 8'(q + 103), man, 13'd0};
            end
        end
        else if (h[14:10] == 5'h1F)
        begin
            res = {h[15], 8'hFF, h[9:0], 13'd0};
        end
        else
        begin
            res = {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
        end
        return res;
    endfunction

    function automatic logic [31:0] int8_to_single(input logic signed [7:0] v);
        logic [7:0]  mag;
        logic [31:0] res;
        mag = v[7] ? 8'(-v) : 8'(v);
        if (mag == 8'd0)
        begin
            res = POS_ZERO;
        end
        else
        begin
            res = fp_round(v[7], 12'sd0, 51'(mag));
        end
        return res;
    endfunction

endpackage

// ----- hdl/twdp_if.sv -----
`timescale 1ns / 1ps

interface twdp_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        weight_code;
    logic [15:0]       page_scale;
    logic signed [7:0] lane_scale;
    logic              outlier_valid;
    logic [15:0]       outlier_value;
    logic [31:0]       activation_value;
    logic              last_in_row;

    modport source (
        output valid, weight_code, page_scale, lane_scale, outlier_valid,
               outlier_value, activation_value, last_in_row,
        input  ready
    );
    modport sink (
        input  valid, weight_code, page_scale, lane_scale, outlier_valid,
               outlier_value, activation_value, last_in_row,
        output ready
    );
endinterface

interface twdp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_result;

    modport source (
        output valid, dot_result,
        input  ready
    );
    modport sink (
        input  valid, dot_result,
        output ready
    );
endinterface

// ----- hdl/twdp_fpu.sv -----
`timescale 1ns / 1ps

module twdp_fpu (
    input  logic             clk,
    input  logic             start,
    input  twdp_pkg::fpu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      result
);
    import twdp_pkg::*;

    fpu_raw_t    raw_reg;
    fpu_raw_t    raw_next;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb, m_big, m_small;
    logic [8:0]  eu_a, eu_b, eu_big, eu_small;
    logic        a_big;
    logic        s_big;
    logic [8:0]  exp_gap;
    logic [49:0] big_full, small_full, small_sh, low_mask;
    logic        stk;
    logic [50:0] sum;
    logic [47:0] prod;

    always_comb
    begin
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        eu_a   = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
        eu_b   = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
        a_big  = a[30:0] >= b[30:0];
        m_big    = a_big ? ma : mb;
        m_small  = a_big ? mb : ma;
        eu_big   = a_big ? eu_a : eu_b;
        eu_small = a_big ? eu_b : eu_a;
        s_big    = a_big ? a[31] : b[31];
        exp_gap  = eu_big - eu_small;
        big_full   = {m_big, 26'd0};
        small_full = {m_small, 26'd0};
        low_mask   = '0;
        if (exp_gap >= 9'd50)
        begin
            small_sh = '0;
            stk = 1'b1;
        end
        else
        begin
            small_sh = small_full >> exp_gap;
            low_mask = (50'd1 << exp_gap) - 50'd1;
            stk = |(small_full & low_mask);
        end
        small_sh[0] = small_sh[0] | stk;
        if (a[31] == b[31])
        begin
            sum = {1'b0, big_full} + {1'b0, small_sh};
        end
        else
        begin
            sum = {1'b0, big_full} - {1'b0, small_sh};
        end
        prod = ma * mb;

        raw_next.special     = 1'b0;
        raw_next.special_val = POS_ZERO;
        raw_next.sgn         = 1'b0;
        raw_next.ex          = '0;
        raw_next.mant        = '0;
        case (op)
            FPU_MUL:
            begin
                raw_next.special = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                begin
                    raw_next.special_val = CANON_NAN;
                end
                else if (a_inf || b_inf)
                begin
                    raw_next.special_val = {a[31] ^ b[31], 8'hFF, 23'd0};
                end
                else
                begin
                    raw_next.special_val = {a[31] ^ b[31], 31'd0};
                end
                raw_next.sgn  = a[31] ^ b[31];
                raw_next.ex   = 12'(signed'({3'd0, eu_a}) + signed'({3'd0, eu_b}) - 12'sd300);
                raw_next.mant = 51'(prod);
            end
            FPU_ADD:
            begin
                raw_next.special = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero
                                   || (sum == 51'd0);
                if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
                begin
                    raw_next.special_val = CANON_NAN;
                end
                else if (a_inf)
                begin
                    raw_next.special_val = a;
                end
                else if (b_inf)
                begin
                    raw_next.special_val = b;
                end
                else if (a_zero && b_zero)
                begin
                    raw_next.special_val = {a[31] & b[31], 31'd0};
                end
                else if (a_zero)
                begin
                    raw_next.special_val = b;
                end
                else if (b_zero)
                begin
                    raw_next.special_val = a;
                end
                else
                begin
                    raw_next.special_val = POS_ZERO;
                end
                raw_next.sgn  = s_big;
                raw_next.ex   = 12'(signed'({3'd0, eu_big}) - 12'sd176);
                raw_next.mant = sum;
            end
            default:
            begin
                raw_next.special = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            raw_reg <= raw_next;
        end
    end

    assign result = raw_reg.special ? raw_reg.special_val
                                    : fp_round(raw_reg.sgn, raw_reg.ex, raw_reg.mant);

endmodule

// ----- hdl/twdp_dp.sv -----
`timescale 1ns / 1ps

module twdp_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               act_half,
    input  twdp_pkg::dp_cmd_t  cmd,
    output twdp_pkg::dp_stat_t stat,
    input  logic [1:0]         weight_code,
    input  logic [15:0]        page_scale,
    input  logic signed [7:0]  lane_scale,
    input  logic               outlier_valid,
    input  logic [15:0]        outlier_value,
    input  logic [31:0]        activation_value,
    input  logic               last_in_row,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [31:0]        dot_result
);
    import twdp_pkg::*;

    logic [1:0]        code_reg;
    logic [15:0]       page_reg;
    logic signed [7:0] lane_in_reg;
    logic              direct_reg;
    logic              last_reg;
    logic [31:0]       act_reg;
    logic [31:0]       lane_reg;
    logic [31:0]       weight_reg;
    logic [31:0]       prod_reg;
    logic [31:0]       sum_reg;
    logic              out_valid_reg;
    logic [31:0]       out_reg;
    logic [31:0]       op_a;
    logic [31:0]       op_b;
    fpu_op_t           op;
    logic [31:0]       fpu_res;
    logic              sum_nan;

    always_comb
    begin
        op   = FPU_MUL;
        op_a = int8_to_single(lane_in_reg);
        op_b = RECIP_127;
        case (cmd.step)
            STEP_LANE:
            begin
                op_a = int8_to_single(lane_in_reg);
                op_b = RECIP_127;
            end
            STEP_MAG:
            begin
                op_a = half_to_single(page_reg);
                op_b = lane_reg;
            end
            STEP_PROD:
            begin
                op_a = weight_reg;
                op_b = act_reg;
            end
            STEP_ACC:
            begin
                op   = FPU_ADD;
                op_a = sum_reg;
                op_b = prod_reg;
            end
            default:
            begin
                op = FPU_MUL;
            end
        endcase
    end

    twdp_fpu u_fpu (
        .clk    (clk),
        .start  (cmd.start),
        .op     (op),
        .a      (op_a),
        .b      (op_b),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg    <= weight_code;
            page_reg    <= page_scale;
            lane_in_reg <= lane_scale;
            direct_reg  <= outlier_valid
                           || ((weight_code != CODE_PLUS) && (weight_code != CODE_MINUS));
            last_reg    <= last_in_row;
            act_reg     <= act_half ? half_to_single(activation_value[15:0]) : activation_value;
            weight_reg  <= outlier_valid ? half_to_single(outlier_value) : POS_ZERO;
        end
        else if (cmd.commit)
        begin
            case (cmd.step)
                STEP_LANE:
                begin
                    lane_reg <= fpu_res;
                end
                STEP_MAG:
                begin
                    weight_reg <= {fpu_res[31] ^ (code_reg == CODE_MINUS), fpu_res[30:0]};
                end
                STEP_PROD:
                begin
                    prod_reg <= fpu_res;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sum_nan = (sum_reg[30:23] == 8'hFF) && (sum_reg[22:0] != 23'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= POS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                sum_reg <= POS_ZERO;
            end
            else if (cmd.commit && (cmd.step == STEP_ACC))
            begin
                sum_reg <= fpu_res;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= sum_nan ? CANON_NAN : sum_reg;
        end
    end

    assign stat.direct   = direct_reg;
    assign stat.last     = last_reg;
    assign stat.out_full = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign dot_result    = out_reg;

endmodule

// ----- hdl/twdp_ctrl.sv -----
`timescale 1ns / 1ps

module twdp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  twdp_pkg::dp_stat_t stat,
    output twdp_pkg::dp_cmd_t  cmd
);
    import twdp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LANE_A = 10'b00_0000_0010,
        S_LANE_B = 10'b00_0000_0100,
        S_MAG_A  = 10'b00_0000_1000,
        S_MAG_B  = 10'b00_0001_0000,
        S_PROD_A = 10'b00_0010_0000,
        S_PROD_B = 10'b00_0100_0000,
        S_ACC_A  = 10'b00_1000_0000,
        S_ACC_B  = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = STEP_LANE;
        cmd.start  = 1'b0;
        cmd.commit = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LANE_A;
                end
            end
            S_LANE_A:
            begin
                cmd.start  = 1'b1;
                state_next = stat.direct ? S_PROD_A : S_LANE_B;
            end
            S_LANE_B:
            begin
                cmd.commit = 1'b1;
                state_next = S_MAG_A;
            end
            S_MAG_A:
            begin
                cmd.step   = STEP_MAG;
                cmd.start  = 1'b1;
                state_next = S_MAG_B;
            end
            S_MAG_B:
            begin
                cmd.step   = STEP_MAG;
                cmd.commit = 1'b1;
                state_next = S_PROD_A;
            end
            S_PROD_A:
            begin
                cmd.step   = STEP_PROD;
                cmd.start  = 1'b1;
                state_next = S_PROD_B;
            end
            S_PROD_B:
            begin
                cmd.step   = STEP_PROD;
                cmd.commit = 1'b1;
                state_next = S_ACC_A;
            end
            S_ACC_A:
            begin
                cmd.step   = STEP_ACC;
                cmd.start  = 1'b1;
                state_next = S_ACC_B;
            end
            S_ACC_B:
            begin
                cmd.step   = STEP_ACC;
                cmd.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!stat.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/ternary_weight_dot_product.sv -----
`timescale 1ns / 1ps
// Accumulates weight times activation over a row of ternary weight columns in single
// precision and delivers the row sum as one output beat on the column marked last, then
// restarts from zero. A new item is accepted only once the previous one has finished its
// steps, and an item whose weight is zero or an outlier commits no lane scale and skips the
// page scale step. One shared two-stage floating-point unit runs the lane scale, page scale,
// product and accumulate steps in turn, each as a start and a commit state. A last
// item waits further while the previous result beat has not been taken. NaN sums are
// delivered as the canonical quiet NaN. The activation format register should only be
// written while no item is in flight.

module ternary_weight_dot_product (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    twdp_in_if.sink     in_item,
    twdp_out_if.source  out_item
);
    import twdp_pkg::*;

    logic     act_half_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_half_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACT_HALF))
        begin
            act_half_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACT_HALF) ? {31'd0, act_half_reg} : 32'd0;

    twdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    twdp_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .act_half         (act_half_reg),
        .cmd              (cmd),
        .stat             (stat),
        .weight_code      (in_item.weight_code),
        .page_scale       (in_item.page_scale),
        .lane_scale       (in_item.lane_scale),
        .outlier_valid    (in_item.outlier_valid),
        .outlier_value    (in_item.outlier_value),
        .activation_value (in_item.activation_value),
        .last_in_row      (in_item.last_in_row),
        .out_ready        (out_item.ready),
        .out_valid        (out_item.valid),
        .dot_result       (out_item.dot_result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_item.valid && in_item.ready) |=> !in_item.ready)
        else $error("input accepted while an item is still in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_item.valid) |-> $past(!in_item.ready))
        else $error("result beat appeared without an item in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] != REG_ACT_HALF)) |=> $stable(act_half_reg))
        else $error("write outside the register map changed the format register");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import twdp_pkg::*;

    localparam logic [2:0] ADDR_ACT_HALF = 3'(4 * REG_ACT_HALF);
    localparam int         HOLD_CYCLES   = 400;

    typedef struct {
        logic [1:0]        code;
        logic [15:0]       page;
        logic signed [7:0] lane;
        logic              ov;
        logic [15:0]       ov_val;
        logic [31:0]       act;
        logic              last;
    } column_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    twdp_in_if  in_bus ();
    twdp_out_if out_bus ();

    ternary_weight_dot_product DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_item  (in_bus),
        .out_item (out_bus)
    );

    column_t     columns[$];
    logic [31:0] row_sums[$];
    logic [31:0] row_acc;
    logic        act_half;
    logic        idle_on;
    int          fail_count;
    int          hold_req;
    int          hold_seen;

    function automatic logic is_nan(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] == 23'd0;
    endfunction

    function automatic logic is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    // Rounds s * m * 2^e to single precision, nearest even; m must be nonzero.
    function automatic logic [31:0] sp_round(input logic s, input int e, input logic [319:0] m);
        int           p;
        int           lsb;
        int           sh;
        logic [319:0] q;
        logic         g;
        logic         st;
        logic [25:0]  mt;
        p = 0;
        for (int i = 0; i < 320; i++)
        begin
            if (m[i])
            begin
                p = i;
            end
        end
        lsb = (p + e < -126) ? -149 : p + e - 23;
        sh = lsb - e;
        g = 1'b0;
        st = 1'b0;
        if (sh <= 0)
        begin
            q = m << (-sh);
        end
        else
        begin
            q = m >> sh;
            g = m[sh - 1];
            st = (sh > 1) ? ((m << (321 - sh)) != '0) : 1'b0;
        end
        mt = q[25:0];
        if (g && (st || mt[0]))
        begin
            mt = mt + 26'd1;
        end
        if (mt[24])
        begin
            mt = mt >> 1;
            lsb = lsb + 1;
        end
        if (!mt[23])
        begin
            return {s, 8'd0, mt[22:0]};
        end
        if (lsb + 150 >= 255)
        begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, 8'(lsb + 150), mt[22:0]};
    endfunction

    function automatic void sp_split(input logic [31:0] b, output logic [319:0] m,
                                     output int e);
        if (b[30:23] == 8'd0)
        begin
            m = 320'(b[22:0]);
            e = -149;
        end
        else
        begin
            m = 320'({1'b1, b[22:0]});
            e = int'(b[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [319:0] ma;
        logic [319:0] mb;
        int           ea;
        int           eb;
        logic         s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
        begin
            return CANON_NAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (is_zero(a) || is_zero(b))
        begin
            return {s, 31'd0};
        end
        sp_split(a, ma, ea);
        sp_split(b, mb, eb);
        return sp_round(s, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic [319:0] ma;
        logic [319:0] mb;
        int           ea;
        int           eb;
        int           emin;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
        begin
            return CANON_NAN;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if (is_zero(a) && is_zero(b))
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (is_zero(a))
        begin
            return b;
        end
        if (is_zero(b))
        begin
            return a;
        end
        sp_split(a, ma, ea);
        sp_split(b, mb, eb);
        emin = (ea < eb) ? ea : eb;
        ma = ma << (ea - emin);
        mb = mb << (eb - emin);
        if (a[31] == b[31])
        begin
            return sp_round(a[31], emin, ma + mb);
        end
        if (ma == mb)
        begin
            return POS_ZERO;
        end
        if (ma > mb)
        begin
            return sp_round(a[31], emin, ma - mb);
        end
        return sp_round(b[31], emin, mb - ma);
    endfunction

    function automatic logic [31:0] half_bits_to_sp(input logic [15:0] h);
        if (h[14:10] == 5'h1F)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        if (h[14:0] == 15'd0)
        begin
            return {h[15], 31'd0};
        end
        if (h[14:10] == 5'd0)
        begin
            return sp_round(h[15], -24, 320'(h[9:0]));
        end
        return sp_round(h[15], int'(h[14:10]) - 25, 320'({1'b1, h[9:0]}));
    endfunction

    task automatic fold_column(input column_t c);
        logic [31:0] weight;
        logic [31:0] lane_f;
        logic [31:0] act;
        logic [7:0]  mag;
        if (c.ov)
        begin
            weight = half_bits_to_sp(c.ov_val);
        end
        else if (c.code == CODE_PLUS || c.code == CODE_MINUS)
        begin
            mag = c.lane[7] ? 8'(-c.lane) : 8'(c.lane);
            lane_f = (mag == 8'd0) ? POS_ZERO : sp_round(c.lane[7], 0, 320'(mag));
            weight = sp_mul(half_bits_to_sp(c.page), sp_mul(lane_f, RECIP_127));
            if (c.code == CODE_MINUS)
            begin
                weight[31] = ~weight[31];
            end
        end
        else
        begin
            weight = POS_ZERO;
        end
        act = act_half ? half_bits_to_sp(c.act[15:0]) : c.act;
        row_acc = sp_add(row_acc, sp_mul(weight, act));
        if (c.last)
        begin
            row_sums.push_back(is_nan(row_acc) ? CANON_NAN : row_acc);
            row_acc = POS_ZERO;
        end
    endtask

    function automatic logic [15:0] pick_half();
        if ($urandom_range(0, 9) < 8)
        begin
            return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
        end
        return 16'($urandom);
    endfunction

    function automatic column_t pick_column(input logic last);
        column_t c;
        c.code = 2'($urandom);
        c.page = pick_half();
        c.lane = 8'($urandom);
        c.ov = ($urandom_range(0, 7) == 0);
        c.ov_val = pick_half();
        if (act_half)
        begin
            c.act = {16'($urandom), pick_half()};
        end
        else if ($urandom_range(0, 9) < 8)
        begin
            c.act = {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        end
        else
        begin
            c.act = $urandom;
        end
        c.last = last;
        return c;
    endfunction

    function automatic column_t make_column(input logic [1:0] code, input logic [15:0] page,
                                            input logic [7:0] lane, input logic ov,
                                            input logic [15:0] ov_val,
                                            input logic [31:0] act, input logic last);
        column_t c;
        c.code = code;
        c.page = page;
        c.lane = lane;
        c.ov = ov;
        c.ov_val = ov_val;
        c.act = act;
        c.last = last;
        return c;
    endfunction

    task automatic queue_rows(input int n);
        int len;
        int k;
        k = 0;
        while (k < n)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    columns.push_back(pick_column(1'($urandom)));
                end
                else
                begin
                    columns.push_back(pick_column(i == len - 1));
                end
            end
            k = k + len;
        end
    endtask

    task automatic drain();
        wait (columns.size() == 0 && !in_bus.valid);
        wait (row_sums.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_act_half(input logic v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ACT_HALF;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        act_half = v;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        int   gap;
        column_t cur;
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
            in_bus.weight_code <= '0;
            in_bus.page_scale <= '0;
            in_bus.lane_scale <= '0;
            in_bus.outlier_valid <= 1'b0;
            in_bus.outlier_value <= '0;
            in_bus.activation_value <= '0;
            in_bus.last_in_row <= 1'b0;
            gap = 0;
        end
        else
        begin
            nv = in_bus.valid;
            if (in_bus.valid && in_bus.ready)
            begin
                fold_column(cur);
                nv = 1'b0;
                gap = idle_on ? $urandom_range(0, 15) : 0;
            end
            if (!nv)
            begin
                if (gap > 0)
                begin
                    gap = gap - 1;
                end
                else if (columns.size() > 0)
                begin
                    cur = columns.pop_front();
                    nv = 1'b1;
                    in_bus.weight_code <= cur.code;
                    in_bus.page_scale <= cur.page;
                    in_bus.lane_scale <= cur.lane;
                    in_bus.outlier_valid <= cur.ov;
                    in_bus.outlier_value <= cur.ov_val;
                    in_bus.activation_value <= cur.act;
                    in_bus.last_in_row <= cur.last;
                end
            end
            in_bus.valid <= nv;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic        nr;
        int          stall;
        int          hold_left;
        logic [31:0] want;
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            stall = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (row_sums.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result beat %h", out_bus.dot_result);
                    end
                end
                else
                begin
                    want = row_sums.pop_front();
                    if (want !== out_bus.dot_result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("dot_result: expected %h, got %h", want,
                                     out_bus.dot_result);
                        end
                    end
                end
                stall = idle_on ? $urandom_range(0, 15) : 0;
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                nr = 1'b0;
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                nr = 1'b0;
            end
            else
            begin
                nr = 1'b1;
            end
            out_bus.ready <= nr;
        end
    end

    initial
    begin
        #(3_000_000);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        act_half = 1'b0;
        row_acc = POS_ZERO;
        idle_on = 1'b1;
        fail_count = 0;
        hold_req = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_act_half(1'b0);
        columns.push_back(make_column(2'd0, 16'h3C00, 8'sd5, 0, 0, 32'h3F80_0000, 1));
        columns.push_back(make_column(2'd1, 16'h3C00, 8'sd127, 0, 0, 32'h3F80_0000, 0));
        columns.push_back(make_column(2'd2, 16'h4000, -8'sd128, 0, 0, 32'h4040_0000, 0));
        columns.push_back(make_column(2'd3, 16'h7C00, 8'sd1, 0, 0, 32'h3F80_0000, 1));
        columns.push_back(make_column(2'd1, 16'h7BFF, 8'sd127, 0, 0, 32'h7F7F_FFFF, 1));
        columns.push_back(make_column(2'd1, 16'h0001, -8'sd1, 0, 0, 32'h0000_0001, 1));
        columns.push_back(make_column(2'd2, 16'h0000, 8'sd0, 1, 16'h03FF, 32'h4000_0000, 1));
        columns.push_back(make_column(2'd1, 16'h7C00, 8'sd3, 0, 0, 32'h3F80_0000, 0));
        columns.push_back(make_column(2'd2, 16'h7C00, 8'sd3, 0, 0, 32'h3F80_0000, 1));
        columns.push_back(make_column(2'd1, 16'h7E01, 8'sd3, 0, 0, 32'hBF80_0000, 1));
        columns.push_back(make_column(2'd0, 16'hFFFF, -8'sd1, 1, 16'hFC00, 32'h0000_0000, 1));
        columns.push_back(make_column(2'd2, 16'hBC00, 8'sd64, 0, 0, 32'hFFFF_FFFF, 1));
        columns.push_back(make_column(2'd0, 16'h0000, 8'sd0, 1, 16'h8000, 32'h8000_0000, 1));
        drain();
        queue_rows(280);
        drain();

        write_act_half(1'b1);
        idle_on = 1'b0;
        columns.push_back(make_column(2'd1, 16'h3C00, 8'sd127, 0, 0, 32'hFFFF_3C00, 1));
        columns.push_back(make_column(2'd2, 16'h3C00, 8'sd127, 0, 0, 32'hABCD_7C00, 0));
        columns.push_back(make_column(2'd1, 16'h3C00, 8'sd127, 0, 0, 32'h0000_0001, 1));
        columns.push_back(make_column(2'd0, 16'h3C00, 8'sd1, 1, 16'h7BFF, 32'h1234_FFFF, 1));
        columns.push_back(make_column(2'd3, 16'h3C00, 8'sd1, 0, 0, 32'h5555_7E00, 1));
        queue_rows(120);
        hold_req = hold_req + 1;
        queue_rows(130);
        drain();

        write_act_half(1'b0);
        idle_on = 1'b1;
        queue_rows(250);
        drain();

        if (fail_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- ternary_weight_dot_product.f -----
hdl/twdp_pkg.sv
hdl/twdp_if.sv
hdl/twdp_fpu.sv
hdl/twdp_dp.sv
hdl/twdp_ctrl.sv
hdl/ternary_weight_dot_product.sv
sim/tb.sv
